/* src/frame_field_deframer_core_macros.svh */
// Assertion macros for the frame field deframer.
// FFD_ASSERT checks a property that is ignored while reset is asserted.
// FFD_ASSERT_ANY checks a property at every clock edge, reset included.
`ifndef FRAME_FIELD_DEFRAMER_CORE_MACROS_SVH
`define FRAME_FIELD_DEFRAMER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FFD_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFD_ASSERT(lbl, prop, msg)
`define FFD_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

/* src/ffd_pkg.sv */
package ffd_pkg;

	localparam int HDR_LEN = 14;
	localparam int MAX_MESSAGE_BYTES = 128;
	localparam int REC_BYTES = 11;
	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] HDR_LEN_B = 8'(HDR_LEN);
	localparam logic [7:0] MAX_BYTES_B = 8'(MAX_MESSAGE_BYTES);
	localparam logic [7:0] HDR_SUM_END = 8'd11;

	localparam logic [7:0] REC_TYPE_S8 = 8'd3;
	localparam logic [7:0] REC_TYPE_S16A = 8'd4;
	localparam logic [7:0] REC_TYPE_S16B = 8'd5;
	localparam logic [7:0] REC_TYPE_DUAL = 8'd10;

	localparam logic [1:0] FMT_S8 = 2'd0;
	localparam logic [1:0] FMT_S16A = 2'd1;
	localparam logic [1:0] FMT_S16B = 2'd2;
	localparam logic [1:0] FMT_DUAL = 2'd3;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic kind;
		logic [7:0] field_id;
		logic [1:0] fmt;
		logic signed [31:0] value_first;
		logic signed [31:0] value_second;
		logic header_ok;
		logic [31:0] network_id;
		logic [31:0] device_id;
		logic [7:0] message_id;
		logic last;
	} result_t;

endpackage

/* src/frame_field_deframer_core.sv */
// Each result is written into a four-entry result queue on the transfer of the byte
// that causes it. Throughput: one byte per cycle while in_ready is high (the queue
// holds at most two results); a byte ending a record and the frame yields two results.
// Reset: arst_n clears the byte position, header and record checksums, record tracking,
// the result queue and send_data_id. Stored header and record bytes are not cleared.
`include "frame_field_deframer_core_macros.svh"

module frame_field_deframer_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] send_data_id,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic end_of_message,
	output logic out_valid,
	input logic out_ready,
	output logic result_kind,
	output logic [7:0] field_id,
	output logic [1:0] value_format,
	output logic signed [31:0] value_first,
	output logic signed [31:0] value_second,
	output logic header_ok,
	output logic [31:0] network_id,
	output logic [31:0] device_id,
	output logic [7:0] message_id,
	output logic last
);
	import ffd_pkg::*;

	logic [7:0] sdid_q;
	logic [7:0] pos_q;
	logic [7:0] hsum_q;
	logic [7:0] hb_q [HDR_LEN];
	logic [7:0] rs_q;
	logic [7:0] rb_q [REC_BYTES];
	logic [7:0] rsum_q;
	result_t slot_q [QDEPTH];
	logic [QCNT_W-1:0] count_q;

	logic accept;
	logic pop;
	logic active;
	logic hdr_wr;
	logic [7:0] pos_new;
	logic [7:0] hsum_new;
	logic [7:0] hb_new [HDR_LEN];
	logic [7:0] hbv [9];
	logic in_rec;
	logic at_start;
	logic after;
	logic [7:0] k;
	logic [8:0] rec_len;
	logic done;
	logic type_ok;
	logic emit;
	result_t rec_res;
	result_t stat_res;
	result_t first_res;
	logic push_first;
	logic push_second;
	logic [QCNT_W-1:0] base;

	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;
	assign in_ready = count_q <= QCNT_W'(QDEPTH - 2);
	assign out_valid = count_q != '0;
	assign pop = out_valid && out_ready;

	assign active = pos_q < MAX_BYTES_B;
	assign hdr_wr = active && (pos_q < HDR_LEN_B);
	assign pos_new = active ? pos_q + 8'd1 : pos_q;
	assign hsum_new = (hdr_wr && pos_q < HDR_SUM_END) ? hsum_q + data_byte : hsum_q;

	always_comb begin
		for (int i = 0; i < HDR_LEN; i++) begin
			hb_new[i] = (hdr_wr && pos_q[3:0] == 4'(i)) ? data_byte : hb_q[i];
		end
		for (int i = 0; i < 9; i++) begin
			hbv[i] = (8'(i) < pos_new) ? hb_new[i] : 8'd0;
		end
	end

	assign in_rec = active && !(pos_q < HDR_LEN_B);
	assign at_start = in_rec && pos_q == rs_q;
	assign after = in_rec && pos_q > rs_q;
	assign k = pos_q - rs_q;
	assign rec_len = {1'b0, rb_q[0]} + 9'd2;
	assign done = after && ({1'b0, k} + 9'd1 == rec_len);
	assign type_ok = rb_q[0] == REC_TYPE_S8 || rb_q[0] == REC_TYPE_S16A
		|| rb_q[0] == REC_TYPE_S16B || rb_q[0] == REC_TYPE_DUAL;
	assign emit = done && type_ok && hb_q[8] == sdid_q && rsum_q == data_byte;

	always_comb begin
		rec_res = '0;
		rec_res.kind = KIND_DATA;
		rec_res.field_id = rb_q[1];
		unique case (rb_q[0])
			REC_TYPE_S8: begin
				rec_res.fmt = FMT_S8;
				rec_res.value_first = 32'(signed'(rb_q[3]));
			end
			REC_TYPE_S16A: begin
				rec_res.fmt = FMT_S16A;
				rec_res.value_first = 32'(signed'({rb_q[3], rb_q[4]}));
			end
			REC_TYPE_S16B: begin
				rec_res.fmt = FMT_S16B;
				rec_res.value_first = 32'(signed'({rb_q[3], rb_q[4]}));
			end
			REC_TYPE_DUAL: begin
				rec_res.fmt = FMT_DUAL;
				rec_res.value_first = {rb_q[3], rb_q[4], rb_q[5], rb_q[6]};
				rec_res.value_second = {rb_q[7], rb_q[8], rb_q[9], rb_q[10]};
			end
			default: begin
				rec_res.fmt = FMT_S8;
			end
		endcase
	end

	always_comb begin
		stat_res = '0;
		stat_res.kind = KIND_STATUS;
		stat_res.header_ok = !(pos_new < HDR_LEN_B) && hb_new[12] == hb_new[13]
			&& hsum_new == hb_new[11];
		stat_res.network_id = {hbv[0], hbv[1], hbv[2], hbv[3]};
		stat_res.device_id = {hbv[4], hbv[5], hbv[6], hbv[7]};
		stat_res.message_id = hbv[8];
		stat_res.last = 1'b1;
	end

	assign first_res = emit ? rec_res : stat_res;
	assign push_first = accept && (emit || end_of_message);
	assign push_second = accept && emit && end_of_message;
	assign base = count_q - QCNT_W'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sdid_q <= 8'd0;
			pos_q <= 8'd0;
			hsum_q <= 8'd0;
			rs_q <= HDR_LEN_B;
			rsum_q <= 8'd0;
			count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sdid_q <= send_data_id;
			end
			count_q <= base + QCNT_W'(push_first) + QCNT_W'(push_second);
			if (accept) begin
				if (end_of_message) begin
					pos_q <= 8'd0;
					hsum_q <= 8'd0;
					rs_q <= HDR_LEN_B;
					rsum_q <= 8'd0;
				end else begin
					pos_q <= pos_new;
					hsum_q <= hsum_new;
					if (at_start) begin
						rsum_q <= data_byte;
					end else if (done) begin
						rs_q <= pos_q + 8'd1;
					end else if (after) begin
						rsum_q <= rsum_q + data_byte;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hb_q <= hb_new;
			if (at_start) begin
				rb_q[0] <= data_byte;
			end else if (after && k < 8'(REC_BYTES)) begin
				rb_q[k[3:0]] <= data_byte;
			end
		end
		for (int i = 0; i < QDEPTH; i++) begin
			if (push_first && base == QCNT_W'(i)) begin
				slot_q[i] <= first_res;
			end else if (push_second && base + QCNT_W'(1) == QCNT_W'(i)) begin
				slot_q[i] <= stat_res;
			end else if (pop && i < QDEPTH - 1) begin
				slot_q[i] <= slot_q[(i + 1) % QDEPTH];
			end
		end
	end

	assign result_kind = slot_q[0].kind;
	assign field_id = slot_q[0].field_id;
	assign value_format = slot_q[0].fmt;
	assign value_first = slot_q[0].value_first;
	assign value_second = slot_q[0].value_second;
	assign header_ok = slot_q[0].header_ok;
	assign network_id = slot_q[0].network_id;
	assign device_id = slot_q[0].device_id;
	assign message_id = slot_q[0].message_id;
	assign last = slot_q[0].last;

	`FFD_ASSERT_ANY(a_queue_bound, count_q <= QCNT_W'(QDEPTH), "result queue overflow")
	`FFD_ASSERT(a_status_last, out_valid && result_kind == KIND_STATUS |-> last,
		"status result without last")
	`FFD_ASSERT(a_data_clean, out_valid && result_kind == KIND_DATA
		|-> !last && !header_ok && network_id == 32'd0,
		"data result carries header status")
	`FFD_ASSERT(a_frame_restart, accept && end_of_message |=> pos_q == 8'd0 && rs_q == HDR_LEN_B,
		"frame state not restarted after final byte")

endmodule

/* dv/deframer_checker.sv */
module deframer_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [7:0] send_data_id,
	input logic in_valid,
	input logic in_ready,
	input logic [7:0] data_byte,
	input logic end_of_message,
	input logic out_valid,
	input logic out_ready,
	input logic result_kind,
	input logic [7:0] field_id,
	input logic [1:0] value_format,
	input logic signed [31:0] value_first,
	input logic signed [31:0] value_second,
	input logic header_ok,
	input logic [31:0] network_id,
	input logic [31:0] device_id,
	input logic [7:0] message_id,
	input logic last,
	output int fail_count,
	output int pending
);
	import ffd_pkg::*;

	localparam int MAX_REPORTS = 10;

	result_t expected_results[$];
	logic [7:0] sel_id = 8'd0;
	logic [7:0] byte_pos = 8'd0;
	logic [7:0] hdr_sum = 8'd0;
	logic [7:0] hdr_seen[HDR_LEN];
	logic [7:0] rec_start = HDR_LEN_B;
	logic [7:0] rec_seen[12];
	logic [7:0] rec_sum = 8'd0;
	int mismatches = 0;
	int mismatches_q = 0;
	int pending_q = 0;

	assign fail_count = mismatches_q;
	assign pending = pending_q;

	initial begin
		foreach (hdr_seen[i]) hdr_seen[i] = 8'd0;
		foreach (rec_seen[i]) rec_seen[i] = 8'd0;
	end

	// Header bytes that did not arrive in the current frame read as zero.
	function automatic logic [7:0] hdr_at(int idx);
		return (idx < int'(byte_pos)) ? hdr_seen[idx] : 8'd0;
	endfunction

	function automatic string result_text(result_t r);
		return $sformatf("kind=%0d id=%h fmt=%0d v1=%h v2=%h ok=%0d net=%h dev=%h msg=%h last=%0d",
			r.kind, r.field_id, r.fmt, r.value_first, r.value_second, r.header_ok,
			r.network_id, r.device_id, r.message_id, r.last);
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic eom);
		int p;
		int k;
		int len;
		int i;
		logic [7:0] t;
		logic known;
		result_t r;
		p = int'(byte_pos);
		if (p < MAX_MESSAGE_BYTES) begin
			if (p < HDR_LEN) begin
				hdr_seen[p] = b;
				if (p < int'(HDR_SUM_END)) hdr_sum = hdr_sum + b;
			end else if (p == int'(rec_start)) begin
				rec_seen[0] = b;
				rec_sum = b;
			end else if (p > int'(rec_start)) begin
				k = p - int'(rec_start);
				len = int'(rec_seen[0]) + 2;
				if (k < 12) rec_seen[k] = b;
				if (k + 1 == len) begin
					t = rec_seen[0];
					r = '0;
					r.kind = KIND_DATA;
					r.field_id = rec_seen[1];
					known = 1'b1;
					case (t)
						REC_TYPE_S8: begin
							r.fmt = FMT_S8;
							r.value_first = {{24{rec_seen[3][7]}}, rec_seen[3]};
						end
						REC_TYPE_S16A: begin
							r.fmt = FMT_S16A;
							r.value_first = {{16{rec_seen[3][7]}}, rec_seen[3], rec_seen[4]};
						end
						REC_TYPE_S16B: begin
							r.fmt = FMT_S16B;
							r.value_first = {{16{rec_seen[3][7]}}, rec_seen[3], rec_seen[4]};
						end
						REC_TYPE_DUAL: begin
							r.fmt = FMT_DUAL;
							r.value_first = {rec_seen[3], rec_seen[4], rec_seen[5], rec_seen[6]};
							r.value_second = {rec_seen[7], rec_seen[8], rec_seen[9], rec_seen[10]};
						end
						default: begin
							known = 1'b0;
						end
					endcase
					if (known && hdr_seen[8] == sel_id && rec_sum == b) begin
						expected_results.push_back(r);
					end
					rec_start = (p + 1 > 255) ? 8'd255 : 8'(p + 1);
				end else begin
					rec_sum = rec_sum + b;
				end
			end
			byte_pos = 8'(p + 1);
		end
		if (eom) begin
			r = '0;
			r.kind = KIND_STATUS;
			r.header_ok = (byte_pos >= HDR_LEN_B) && (hdr_seen[12] == hdr_seen[13]) &&
				(hdr_sum == hdr_seen[HDR_SUM_END]);
			for (i = 0; i < 4; i++) begin
				r.network_id = {r.network_id[23:0], hdr_at(i)};
				r.device_id = {r.device_id[23:0], hdr_at(i + 4)};
			end
			r.message_id = hdr_at(8);
			r.last = 1'b1;
			expected_results.push_back(r);
			byte_pos = 8'd0;
			hdr_sum = 8'd0;
			rec_start = HDR_LEN_B;
			rec_sum = 8'd0;
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sel_id = send_data_id;
			if (out_valid && out_ready) begin
				got.kind = result_kind;
				got.field_id = field_id;
				got.fmt = value_format;
				got.value_first = value_first;
				got.value_second = value_second;
				got.header_ok = header_ok;
				got.network_id = network_id;
				got.device_id = device_id;
				got.message_id = message_id;
				got.last = last;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("Result transfer with nothing expected: %s", result_text(got));
					end
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("Result mismatch at %0t", $time);
							$display("  expected %s", result_text(want));
							$display("  actual   %s", result_text(got));
						end
					end
				end
			end
			if (in_valid && in_ready) decode_byte(data_byte, end_of_message);
		end
		mismatches_q <= mismatches;
		pending_q <= expected_results.size();
	end

endmodule

/* dv/tb_top.sv */
module tb_top;
	import ffd_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_BYTES = 1000;
	localparam int FRAMES_PER_PHASE = 6;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TIMEOUT_CYCLES = 600000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] send_data_id;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic end_of_message;
	logic out_valid;
	logic out_ready;
	logic result_kind;
	logic [7:0] field_id;
	logic [1:0] value_format;
	logic signed [31:0] value_first;
	logic signed [31:0] value_second;
	logic header_ok;
	logic [31:0] network_id;
	logic [31:0] device_id;
	logic [7:0] message_id;
	logic last;
	int fail_count;
	int pending;

	logic [7:0] frame_bytes[$];
	logic [7:0] cur_sel = 8'd0;
	int bytes_sent = 0;
	bit hold_req = 1'b0;
	bit no_gaps = 1'b0;

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	frame_field_deframer_core u_dut (.*);

	deframer_checker u_checker (.*);

	function automatic logic [7:0] rand_val();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'h7F;
			2: return 8'h80;
			3: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 85) return int'($urandom_range(1, 3));
		if (r < 97) return int'($urandom_range(4, 10));
		return int'($urandom_range(20, 50));
	endfunction

	function automatic logic [7:0] pick_type();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			case ($urandom_range(0, 3))
				0: return REC_TYPE_S8;
				1: return REC_TYPE_S16A;
				2: return REC_TYPE_S16B;
				default: return REC_TYPE_DUAL;
			endcase
		end
		if (r < 90) return 8'($urandom_range(0, 20));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] sum_of(int lo, int hi);
		logic [7:0] s;
		s = 8'd0;
		for (int i = lo; i <= hi; i++) s = s + frame_bytes[i];
		return s;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eom);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		end
		frame_bytes.delete();
	endtask

	task automatic write_sel(input logic [7:0] v);
		cfg_valid <= 1'b1;
		send_data_id <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_header(input logic [31:0] net, input logic [31:0] dev,
		input logic [7:0] msg, input bit good_sum);
		int i;
		for (i = 3; i >= 0; i--) frame_bytes.push_back(net[8 * i +: 8]);
		for (i = 3; i >= 0; i--) frame_bytes.push_back(dev[8 * i +: 8]);
		frame_bytes.push_back(msg);
		frame_bytes.push_back(rand_val());
		frame_bytes.push_back(rand_val());
		frame_bytes.push_back(good_sum ? sum_of(0, 10) :
			8'(sum_of(0, 10) + 8'($urandom_range(1, 255))));
		frame_bytes.push_back(8'd0);
		frame_bytes.push_back(8'd0);
	endtask

	// Types above twenty get random filler bytes and no checksum byte.
	task automatic add_record(input logic [7:0] t, input bit good_sum);
		int start;
		int i;
		int n;
		start = frame_bytes.size();
		frame_bytes.push_back(t);
		if (t > 8'd20) begin
			n = $urandom_range(0, 30);
			for (i = 0; i < n; i++) frame_bytes.push_back(rand_val());
		end else begin
			for (i = 0; i < int'(t); i++) frame_bytes.push_back(rand_val());
			frame_bytes.push_back(good_sum ? sum_of(start, start + int'(t)) :
				8'(sum_of(start, start + int'(t)) + 8'($urandom_range(1, 255))));
		end
	endtask

	task automatic set_length(input bit same);
		logic [7:0] n;
		n = 8'(frame_bytes.size());
		frame_bytes[12] = n;
		frame_bytes[13] = same ? n : n ^ 8'($urandom_range(1, 255));
	endtask

	task automatic random_frame();
		int r;
		int target;
		int cut;
		logic [7:0] msg;
		r = $urandom_range(0, 99);
		no_gaps = ($urandom_range(0, 99) < 15);
		if (r < 8) begin
			target = $urandom_range(1, 20);
			repeat (target) frame_bytes.push_back(rand_val());
		end else begin
			msg = ($urandom_range(0, 99) < 80) ? cur_sel : 8'($urandom_range(0, 255));
			add_header({rand_val(), rand_val(), rand_val(), rand_val()},
				{rand_val(), rand_val(), rand_val(), rand_val()}, msg,
				$urandom_range(0, 99) < 88);
			target = (r < 18) ? $urandom_range(120, 170) : $urandom_range(16, 70);
			while (frame_bytes.size() < target) begin
				add_record(pick_type(), $urandom_range(0, 99) < 88);
			end
			if ($urandom_range(0, 99) < 20) begin
				cut = $urandom_range(1, 6);
				while (cut > 0 && frame_bytes.size() > HDR_LEN) begin
					void'(frame_bytes.pop_back());
					cut--;
				end
			end
			set_length($urandom_range(0, 99) < 90);
		end
	endtask

	initial begin
		bit rdy;
		int span;
		int r;
		out_ready <= 1'b0;
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					rdy = 1'b1;
					span = $urandom_range(1, 8);
				end else if (r < 70) begin
					rdy = 1'b1;
					span = $urandom_range(20, 60);
				end else if (r < 92) begin
					rdy = 1'b0;
					span = $urandom_range(1, 3);
				end else begin
					rdy = 1'b0;
					span = $urandom_range(10, 40);
				end
				out_ready <= rdy;
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin
		int phase;
		int f;
		logic [7:0] dual_rec[11];
		dual_rec = '{REC_TYPE_DUAL, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h00,
			8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF};
		in_valid <= 1'b0;
		data_byte <= 8'd0;
		end_of_message <= 1'b0;
		cfg_valid <= 1'b0;
		send_data_id <= 8'd0;
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_sel(8'h00);

		// A one-byte frame, then a dual record whose checksum byte also ends the frame.
		send_byte(8'hFF, 1'b1);
		add_header(32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 1'b1);
		foreach (dual_rec[i]) frame_bytes.push_back(dual_rec[i]);
		frame_bytes.push_back(sum_of(HDR_LEN, HDR_LEN + 10));
		set_length(1'b1);
		send_frame();

		phase = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			drain_results();
			case (phase % 4)
				0: cur_sel = 8'hFF;
				2: cur_sel = 8'h00;
				default: cur_sel = 8'($urandom_range(0, 255));
			endcase
			write_sel(cur_sel);
			for (f = 0; f < FRAMES_PER_PHASE && bytes_sent < RANDOM_BYTES; f++) begin
				if (phase == 0 && f == 2) begin
					add_header({rand_val(), rand_val(), rand_val(), rand_val()},
						{rand_val(), rand_val(), rand_val(), rand_val()}, cur_sel, 1'b1);
					repeat (24) add_record(REC_TYPE_S8, 1'b1);
					set_length(1'b1);
					no_gaps = 1'b1;
					hold_req = 1'b1;
				end else begin
					random_frame();
				end
				send_frame();
			end
			phase++;
		end
		drain_results();

		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
